### hw/rtl/hpq_pkg.sv
// Shared types and codes for the max-heap priority queue.
// Used by the key store, the sequencer, the top level and the port checker; depends on nothing.
`default_nettype none

package hpq_pkg;

    localparam int KEY_W = 32;
    localparam int OCC_W = 6;

    typedef logic signed [KEY_W-1:0] key_t;

    // Operation codes carried with each input item.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_APPEND = 2'd2;
    localparam logic [1:0] KIND_BUILD  = 2'd3;

    // Status codes returned with each result item.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        key_t             removed_key;
        logic [1:0]       status;
        logic [OCC_W-1:0] occupancy;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/hpq_mem.sv
// Key store of the heap: one write port and one read port, read data registered.
// Uses the key type from hpq_pkg.
`default_nettype none

module hpq_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output hpq_pkg::key_t      rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire hpq_pkg::key_t wr_data
);
    import hpq_pkg::*;

    key_t mem [DEPTH];
    key_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/hpq_seq.sv
// Operation sequencer: walks the heap through the key store one level at a time.
// Uses hpq_pkg; drives the ports of hpq_mem.
`default_nettype none

module hpq_seq #(
    parameter int CAPACITY = 32,
    parameter int AW       = 5
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    in_kind,
    input  wire hpq_pkg::key_t in_key,
    output logic               res_valid,
    input  wire logic          res_ready,
    output hpq_pkg::res_t      res,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  wire hpq_pkg::key_t rd_data,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output hpq_pkg::key_t      wr_data
);
    import hpq_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b000000000001,
        ST_INS_RD  = 12'b000000000010,
        ST_INS_CMP = 12'b000000000100,
        ST_RM_LAST = 12'b000000001000,
        ST_RM_ROOT = 12'b000000010000,
        ST_RM_TAKE = 12'b000000100000,
        ST_BLD_RD  = 12'b000001000000,
        ST_BLD_LD  = 12'b000010000000,
        ST_SD_RDL  = 12'b000100000000,
        ST_SD_RDR  = 12'b001000000000,
        ST_SD_CMP  = 12'b010000000000,
        ST_RESP    = 12'b100000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] hole_reg, hole_next;
    logic [PW:0]   child_reg, child_next;
    logic [PW-1:0] bld_reg, bld_next;
    logic          bld_mode_reg, bld_mode_next;
    logic          right_reg, right_next;
    key_t          val_reg, val_next;
    key_t          left_reg, left_next;
    key_t          rem_reg, rem_next;
    logic [1:0]    status_reg, status_next;

    logic [PW-1:0] rd_pos, wr_pos;
    logic [PW-1:0] cnt_inc, cnt_dec, cpos;
    logic          pick_right;
    key_t          chosen;
    state_t        sd_done_state;

    assign cnt_inc    = cnt_reg + PW'(1);
    assign cnt_dec    = cnt_reg - PW'(1);
    // Of two equal children the left one wins.
    assign pick_right = right_reg && (left_reg < rd_data);
    assign chosen     = pick_right ? rd_data : left_reg;
    assign cpos       = child_reg[PW-1:0] + PW'(pick_right);
    // A finished sift either moves on to the next build index or ends the item.
    assign sd_done_state = (bld_mode_reg && bld_reg > PW'(1)) ? ST_BLD_RD : ST_RESP;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        hole_next     = hole_reg;
        child_next    = child_reg;
        bld_next      = bld_reg;
        bld_mode_next = bld_mode_reg;
        right_next    = right_reg;
        val_next      = val_reg;
        left_next     = left_reg;
        rem_next      = rem_reg;
        status_next   = status_reg;
        rd_en         = 1'b0;
        rd_pos        = hole_reg;
        wr_en         = 1'b0;
        wr_pos        = hole_reg;
        wr_data       = val_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    rem_next    = '0;
                    status_next = STAT_OK;
                    val_next    = in_key;
                    state_next  = ST_RESP;
                    case (in_kind)
                        KIND_INSERT, KIND_APPEND: begin
                            if (cnt_reg == PW'(CAPACITY)) begin
                                status_next = STAT_FULL;
                            end else begin
                                cnt_next  = cnt_inc;
                                hole_next = cnt_inc;
                                if (in_kind == KIND_APPEND) begin
                                    wr_en   = 1'b1;
                                    wr_pos  = cnt_inc;
                                    wr_data = in_key;
                                end else begin
                                    state_next = ST_INS_RD;
                                end
                            end
                        end
                        KIND_REMOVE: begin
                            if (cnt_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                state_next = ST_RM_LAST;
                            end
                        end
                        default: begin
                            if (cnt_reg >= PW'(2)) begin
                                bld_next      = cnt_reg >> 1;
                                bld_mode_next = 1'b1;
                                state_next    = ST_BLD_RD;
                            end
                        end
                    endcase
                end
            end
            ST_INS_RD: begin
                if (hole_reg == PW'(1)) begin
                    wr_en      = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    rd_en      = 1'b1;
                    rd_pos     = hole_reg >> 1;
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                wr_en = 1'b1;
                if (rd_data < val_reg) begin
                    wr_data    = rd_data;
                    hole_next  = hole_reg >> 1;
                    state_next = ST_INS_RD;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_RM_LAST: begin
                rd_en      = 1'b1;
                rd_pos     = cnt_reg;
                state_next = ST_RM_ROOT;
            end
            ST_RM_ROOT: begin
                val_next   = rd_data;
                rd_en      = 1'b1;
                rd_pos     = PW'(1);
                state_next = ST_RM_TAKE;
            end
            ST_RM_TAKE: begin
                rem_next      = rd_data;
                cnt_next      = cnt_dec;
                hole_next     = PW'(1);
                child_next    = (PW+1)'(2);
                bld_mode_next = 1'b0;
                state_next    = (cnt_dec == '0) ? ST_RESP : ST_SD_RDL;
            end
            ST_BLD_RD: begin
                rd_en      = 1'b1;
                rd_pos     = bld_reg;
                state_next = ST_BLD_LD;
            end
            ST_BLD_LD: begin
                val_next   = rd_data;
                hole_next  = bld_reg;
                child_next = {bld_reg, 1'b0};
                state_next = ST_SD_RDL;
            end
            ST_SD_RDL: begin
                if (child_reg > {1'b0, cnt_reg}) begin
                    wr_en      = 1'b1;
                    bld_next   = bld_reg - PW'(1);
                    state_next = sd_done_state;
                end else begin
                    rd_en      = 1'b1;
                    rd_pos     = child_reg[PW-1:0];
                    state_next = ST_SD_RDR;
                end
            end
            ST_SD_RDR: begin
                left_next  = rd_data;
                right_next = child_reg < {1'b0, cnt_reg};
                rd_en      = child_reg < {1'b0, cnt_reg};
                rd_pos     = child_reg[PW-1:0] + PW'(1);
                state_next = ST_SD_CMP;
            end
            ST_SD_CMP: begin
                wr_en = 1'b1;
                if (val_reg < chosen) begin
                    wr_data    = chosen;
                    hole_next  = cpos;
                    child_next = {cpos, 1'b0};
                    state_next = ST_SD_RDL;
                end else begin
                    bld_next   = bld_reg - PW'(1);
                    state_next = sd_done_state;
                end
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        hole_reg     <= hole_next;
        child_reg    <= child_next;
        bld_reg      <= bld_next;
        bld_mode_reg <= bld_mode_next;
        right_reg    <= right_next;
        val_reg      <= val_next;
        left_reg     <= left_next;
        rem_reg      <= rem_next;
        status_reg   <= status_next;
    end

    // No state both reads and writes the key store, so a read never
    // meets a write to the same entry in one cycle.
    assign rd_addr = AW'(rd_pos - PW'(1));
    assign wr_addr = AW'(wr_pos - PW'(1));

    assign in_ready        = (state_reg == ST_IDLE);
    assign res_valid       = (state_reg == ST_RESP);
    assign res.removed_key = rem_reg;
    assign res.status      = status_reg;
    assign res.occupancy   = OCC_W'(cnt_reg);

endmodule

`default_nettype wire

### hw/rtl/max_heap_priority_queue.sv
// Max-heap priority queue: key store, operation sequencer and result register.
// Instantiates hpq_mem and hpq_seq; uses hpq_pkg.
//
// Usage: each item on the s_ channel carries an operation in s_tuser (insert,
// remove maximum, append without ordering, build heap) and a signed key in
// s_tdata. Every item yields exactly one result item on the m_ channel with the
// removed key, a status code and the number of keys held afterwards.
// The heap lives in a memory with registered read data and one item is in
// work at a time. An insert moves its key up one level at a time; a remove
// moves the last key to the root and sifts it down level by level; a build
// sifts down every parent position, from the last one back to the root.
// The result sits in an output register; a new item is taken as soon as the
// sequencer is idle, even while that register still waits on m_tready, and a
// finished result then waits in the sequencer until the register frees.
// Reset empties the heap at once; the store contents are not cleared because
// only positions already written are ever read.
`default_nettype none

module max_heap_priority_queue #(
    parameter int CAPACITY = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] key
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] removed_key, [37:32] occupancy, [39:38] zero
    output logic [1:0]       m_tuser    // [1:0] status
);
    import hpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          res_valid, res_ready;
    res_t          res;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    key_t          rd_data, wr_data;

    logic          m_valid_reg;
    res_t          out_reg;

    hpq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    hpq_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_key    (key_t'(s_tdata)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_reg.occupancy, out_reg.removed_key};
    assign m_tuser  = out_reg.status;

endmodule

`default_nettype wire

### hw/rtl/hpq_chk.sv
// Port-level checker for the max-heap priority queue, bound to the top level.
// Uses status codes from hpq_pkg.
`default_nettype none

module hpq_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    import hpq_pkg::*;

    // A failed operation never reports a key.
    a_err_zero_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata[31:0] == 32'd0)
        else $error("error result carries a non-zero key");

    // An empty-heap error can only come from a heap holding nothing.
    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_EMPTY |-> m_tdata[37:32] == 6'd0)
        else $error("empty status with non-zero occupancy");

    // Only the three defined status codes and zero padding appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_EMPTY ||
                      m_tuser == STAT_FULL) && m_tdata[39:38] == 2'b00)
        else $error("undefined status or padding on result item");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // Only one item is in work at a time, so input is refused right after an accept.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

endmodule

bind max_heap_priority_queue hpq_chk u_hpq_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
